@@ hdl/m2qs_pkg.sv @@
// Package for the median of two quadratic sequences block.
// Holds widths, register and step codes, state and command types.
// No dependencies.
package m2qs_pkg;

  localparam int VAL_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_A_SQUARE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_A_LINEAR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_A_CONST  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_B_SQUARE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_B_LINEAR = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_B_CONST  = CFG_IDX_W'(5);

  localparam logic [STEP_W-1:0] STEP_SQUARE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_LINEAR = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_LOW    = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_HIGH   = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_SHIFT  = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_STORE  = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_AVG    = STEP_W'(6);

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_CHECK, ST_EVAL, ST_DECIDE, ST_SORT, ST_PICK, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    TGT_A_MID, TGT_B_MID, TGT_AL, TGT_AR, TGT_BL, TGT_BR
  } tgt_t;

  typedef enum logic [2:0] {
    MUL_XX, MUL_C1X, MUL_C2LO, MUL_C2HI, MUL_C2STEP
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_SQ, ACC_LOAD, ACC_ADD, ACC_ADDSH, ACC_NEXT, ACC_STORE, ACC_STORE_AVG
  } acc_op_t;

  typedef enum logic [1:0] {
    RES_NONE, RES_ZERO, RES_AV, RES_PICK
  } res_op_t;

  typedef struct packed {
    logic     load;
    tgt_t     tgt;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     narrow;
    logic     sort;
    res_op_t  res_op;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic converged;
    logic pair;
    logic equal;
    logic a_two;
    logic b_two;
  } status_t;

endpackage

@@ hdl/m2qs_len_if.sv @@
// Input channel carrying the sequence length.
// Depends on nothing beyond its own parameter.
interface m2qs_len_if #(
  parameter int LENGTH_BITS = 20
) ();
  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS:0]   seq_length;

  modport source (output valid, output seq_length, input ready);
  modport sink (input valid, input seq_length, output ready);
endinterface

@@ hdl/m2qs_med_if.sv @@
// Output channel carrying the selected median value.
// Depends on m2qs_pkg for the value width.
interface m2qs_med_if ();
  logic                              valid;
  logic                              ready;
  logic signed [m2qs_pkg::VAL_W-1:0] median_value;

  modport source (output valid, output median_value, input ready);
  modport sink (input valid, input median_value, output ready);
endinterface

@@ hdl/m2qs_cfg_if.sv @@
// Configuration write channel: register index and coefficient data.
// Depends on m2qs_pkg for the index width.
interface m2qs_cfg_if #(
  parameter int COEF_BITS = 16
) ();
  logic                              valid;
  logic                              ready;
  logic [m2qs_pkg::CFG_IDX_W-1:0]    index;
  logic signed [COEF_BITS-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/m2qs_ctrl.sv @@
// Controller: sequences the halving rounds, the quadratic evaluations and the final sort.
// Depends on m2qs_pkg for the state, command and status types.
module m2qs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  m2qs_pkg::status_t st,
  output m2qs_pkg::cmd_t    cmd
);

  m2qs_pkg::state_t                state, state_next;
  m2qs_pkg::tgt_t                  tgt, tgt_next;
  logic [m2qs_pkg::STEP_W-1:0]     step, step_next;
  logic                            eval_done;

  assign eval_done = (step == m2qs_pkg::STEP_STORE && !st.pair) ||
                     (step == m2qs_pkg::STEP_AVG);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m2qs_pkg::ST_IDLE;
      tgt   <= m2qs_pkg::TGT_A_MID;
      step  <= m2qs_pkg::STEP_SQUARE;
    end else begin
      state <= state_next;
      tgt   <= tgt_next;
      step  <= step_next;
    end
  end

  always_comb begin : next_state
    state_next = state;
    tgt_next   = tgt;
    step_next  = step;
    unique case (state)
      m2qs_pkg::ST_IDLE: begin
        if (in_valid) state_next = m2qs_pkg::ST_INIT;
      end
      m2qs_pkg::ST_INIT: begin
        state_next = st.len_zero ? m2qs_pkg::ST_OUT : m2qs_pkg::ST_CHECK;
      end
      m2qs_pkg::ST_CHECK: begin
        state_next = m2qs_pkg::ST_EVAL;
        step_next  = m2qs_pkg::STEP_SQUARE;
        tgt_next   = st.converged ? m2qs_pkg::TGT_AL : m2qs_pkg::TGT_A_MID;
      end
      m2qs_pkg::ST_EVAL: begin
        if (eval_done) begin
          step_next = m2qs_pkg::STEP_SQUARE;
          unique case (tgt)
            m2qs_pkg::TGT_A_MID: tgt_next = m2qs_pkg::TGT_B_MID;
            m2qs_pkg::TGT_B_MID: state_next = m2qs_pkg::ST_DECIDE;
            m2qs_pkg::TGT_AL: tgt_next = st.a_two ? m2qs_pkg::TGT_AR : m2qs_pkg::TGT_BL;
            m2qs_pkg::TGT_AR: tgt_next = m2qs_pkg::TGT_BL;
            m2qs_pkg::TGT_BL: begin
              if (st.b_two) tgt_next = m2qs_pkg::TGT_BR;
              else state_next = m2qs_pkg::ST_SORT;
            end
            m2qs_pkg::TGT_BR: state_next = m2qs_pkg::ST_SORT;
            default: state_next = m2qs_pkg::ST_IDLE;
          endcase
        end else begin
          step_next = step + m2qs_pkg::STEP_W'(1);
        end
      end
      m2qs_pkg::ST_DECIDE: begin
        state_next = st.equal ? m2qs_pkg::ST_OUT : m2qs_pkg::ST_CHECK;
      end
      m2qs_pkg::ST_SORT: state_next = m2qs_pkg::ST_PICK;
      m2qs_pkg::ST_PICK: state_next = m2qs_pkg::ST_OUT;
      m2qs_pkg::ST_OUT: begin
        if (out_ready) state_next = m2qs_pkg::ST_IDLE;
      end
    endcase
  end

  // Each multiplier product is registered before the accumulator consumes it.
  always_comb begin : outputs
    cmd       = '0;
    cmd.tgt   = tgt;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      m2qs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      m2qs_pkg::ST_INIT: begin
        if (st.len_zero) cmd.res_op = m2qs_pkg::RES_ZERO;
      end
      m2qs_pkg::ST_CHECK: ;
      m2qs_pkg::ST_EVAL: begin
        unique case (step)
          m2qs_pkg::STEP_SQUARE: cmd.mul_sel = m2qs_pkg::MUL_XX;
          m2qs_pkg::STEP_LINEAR: begin
            cmd.mul_sel = m2qs_pkg::MUL_C1X;
            cmd.acc_op  = m2qs_pkg::ACC_SQ;
          end
          m2qs_pkg::STEP_LOW: begin
            cmd.mul_sel = m2qs_pkg::MUL_C2LO;
            cmd.acc_op  = m2qs_pkg::ACC_LOAD;
          end
          m2qs_pkg::STEP_HIGH: begin
            cmd.mul_sel = m2qs_pkg::MUL_C2HI;
            cmd.acc_op  = m2qs_pkg::ACC_ADD;
          end
          m2qs_pkg::STEP_SHIFT: begin
            cmd.mul_sel = m2qs_pkg::MUL_C2STEP;
            cmd.acc_op  = m2qs_pkg::ACC_ADDSH;
          end
          m2qs_pkg::STEP_STORE: begin
            cmd.acc_op = st.pair ? m2qs_pkg::ACC_NEXT : m2qs_pkg::ACC_STORE;
          end
          m2qs_pkg::STEP_AVG: cmd.acc_op = m2qs_pkg::ACC_STORE_AVG;
          default: ;
        endcase
      end
      m2qs_pkg::ST_DECIDE: begin
        if (st.equal) cmd.res_op = m2qs_pkg::RES_AV;
        else cmd.narrow = 1'b1;
      end
      m2qs_pkg::ST_SORT: cmd.sort = 1'b1;
      m2qs_pkg::ST_PICK: cmd.res_op = m2qs_pkg::RES_PICK;
      m2qs_pkg::ST_OUT: out_valid = 1'b1;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == m2qs_pkg::ST_INIT)
    else $error("accepted transaction did not start processing");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_avg_only_pair: assert property (@(posedge clk) disable iff (rst)
    state == m2qs_pkg::ST_EVAL && step == m2qs_pkg::STEP_AVG |-> st.pair)
    else $error("averaging step reached for a single midpoint");

endmodule

@@ hdl/m2qs_dp.sv @@
// Datapath: coefficient registers, index windows, shared multiplier with accumulator, sorter.
// Depends on m2qs_pkg for command and status types and register codes.
module m2qs_dp #(
  parameter int COEF_BITS   = 16,
  parameter int LENGTH_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  logic [m2qs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic signed [COEF_BITS-1:0]         cfg_data,
  input  logic [LENGTH_BITS:0]                seq_length,
  input  m2qs_pkg::cmd_t                      cmd,
  output m2qs_pkg::status_t                   st,
  output logic signed [m2qs_pkg::VAL_W-1:0]   median_value
);

  localparam int IW = LENGTH_BITS + 1;
  localparam int BW = IW + 1;
  localparam int AW = (COEF_BITS > IW + 1) ? COEF_BITS : IW + 1;
  localparam int PW = AW + BW + 1;
  localparam int VW = m2qs_pkg::VAL_W;

  logic signed [COEF_BITS-1:0] a2, a1, a0, b2, b1, b0;
  logic signed [COEF_BITS-1:0] c2, c1, c0;
  logic [IW-1:0]               al, ar, bl, br;
  logic [IW:0]                 a_sum, b_sum;
  logic [IW-1:0]               am, bm, x;
  logic                        a_odd, b_odd, is_b, collect;
  logic                        len_zero;
  logic [2:0]                  cnt;
  logic signed [AW-1:0]        mul_a;
  logic [BW-1:0]               mul_b;
  logic signed [PW-1:0]        prod;
  logic signed [VW-1:0]        prod_ext;
  logic [2*IW-1:0]             sq;
  logic [VW-1:0]               acc, first, avg_sum, avg_adj, avg_val, store_val;
  logic                        store_en;
  logic signed [VW-1:0]        av, bv, pick_val;
  logic signed [VW-1:0]        vals [4];
  logic [3:0]                  less [4];
  logic [3:0]                  leq [4];
  logic [2:0]                  nlt [4];
  logic [2:0]                  nle [4];
  logic [1:0]                  rank;
  logic                        found;

  always_ff @(posedge clk) begin
    if (rst) begin
      a2 <= '0; a1 <= '0; a0 <= '0;
      b2 <= '0; b1 <= '0; b0 <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        m2qs_pkg::REG_A_SQUARE: a2 <= cfg_data;
        m2qs_pkg::REG_A_LINEAR: a1 <= cfg_data;
        m2qs_pkg::REG_A_CONST:  a0 <= cfg_data;
        m2qs_pkg::REG_B_SQUARE: b2 <= cfg_data;
        m2qs_pkg::REG_B_LINEAR: b1 <= cfg_data;
        m2qs_pkg::REG_B_CONST:  b0 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign a_sum = {1'b0, al} + {1'b0, ar};
  assign b_sum = {1'b0, bl} + {1'b0, br};
  assign am    = a_sum[IW:1];
  assign bm    = b_sum[IW:1];
  assign a_odd = a_sum[0];
  assign b_odd = b_sum[0];

  assign is_b = (cmd.tgt == m2qs_pkg::TGT_B_MID) || (cmd.tgt == m2qs_pkg::TGT_BL) ||
                (cmd.tgt == m2qs_pkg::TGT_BR);
  assign collect = (cmd.tgt != m2qs_pkg::TGT_A_MID) && (cmd.tgt != m2qs_pkg::TGT_B_MID);
  assign c2 = is_b ? b2 : a2;
  assign c1 = is_b ? b1 : a1;
  assign c0 = is_b ? b0 : a0;

  always_comb begin
    case (cmd.tgt)
      m2qs_pkg::TGT_A_MID: x = am;
      m2qs_pkg::TGT_B_MID: x = bm;
      m2qs_pkg::TGT_AL:    x = al;
      m2qs_pkg::TGT_AR:    x = ar;
      m2qs_pkg::TGT_BL:    x = bl;
      m2qs_pkg::TGT_BR:    x = br;
      default:             x = '0;
    endcase
  end

  // The square x*x is split in halves so that c2*x*x needs two narrow products.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      m2qs_pkg::MUL_XX: begin
        mul_a = AW'($signed({1'b0, x}));
        mul_b = BW'(x);
      end
      m2qs_pkg::MUL_C1X: begin
        mul_a = AW'(c1);
        mul_b = BW'(x);
      end
      m2qs_pkg::MUL_C2LO: begin
        mul_a = AW'(c2);
        mul_b = BW'(sq[IW-1:0]);
      end
      m2qs_pkg::MUL_C2HI: begin
        mul_a = AW'(c2);
        mul_b = BW'(sq[2*IW-1:IW]);
      end
      m2qs_pkg::MUL_C2STEP: begin
        mul_a = AW'(c2);
        mul_b = {x, 1'b1};
      end
      default: ;
    endcase
  end

  assign prod_ext  = VW'(prod);
  assign avg_sum   = first + acc;
  assign avg_adj   = avg_sum + VW'(avg_sum[VW-1]);
  assign avg_val   = {avg_adj[VW-1], avg_adj[VW-1:1]};
  assign store_en  = (cmd.acc_op == m2qs_pkg::ACC_STORE) ||
                     (cmd.acc_op == m2qs_pkg::ACC_STORE_AVG);
  assign store_val = (cmd.acc_op == m2qs_pkg::ACC_STORE_AVG) ? avg_val : acc;

  always_ff @(posedge clk) begin
    prod <= mul_a * $signed({1'b0, mul_b});
    unique case (cmd.acc_op)
      m2qs_pkg::ACC_NONE:  ;
      m2qs_pkg::ACC_SQ:    sq <= prod[2*IW-1:0];
      m2qs_pkg::ACC_LOAD:  acc <= VW'(c0) + prod_ext;
      m2qs_pkg::ACC_ADD:   acc <= acc + prod_ext;
      m2qs_pkg::ACC_ADDSH: acc <= acc + (prod_ext << IW);
      m2qs_pkg::ACC_NEXT: begin
        first <= acc;
        acc   <= acc + prod_ext + VW'(c1);
      end
      m2qs_pkg::ACC_STORE, m2qs_pkg::ACC_STORE_AVG: begin
        if (cmd.tgt == m2qs_pkg::TGT_A_MID) av <= store_val;
        else if (cmd.tgt == m2qs_pkg::TGT_B_MID) bv <= store_val;
        else vals[cnt[1:0]] <= store_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      al       <= '0;
      ar       <= '0;
      bl       <= '0;
      br       <= '0;
      cnt      <= '0;
      len_zero <= 1'b0;
    end else if (cmd.load) begin
      al       <= '0;
      bl       <= '0;
      ar       <= seq_length - IW'(1);
      br       <= seq_length - IW'(1);
      cnt      <= '0;
      len_zero <= (seq_length == '0);
    end else begin
      if (cmd.narrow) begin
        if (av > bv) begin
          ar <= am;
          bl <= b_odd ? bm + IW'(1) : bm;
        end else begin
          al <= a_odd ? am + IW'(1) : am;
          br <= bm;
        end
      end
      if (store_en && collect) cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          less[i][j] <= (3'(j) < cnt) && (vals[j] < vals[i]);
          leq[i][j]  <= (3'(j) < cnt) && !(vals[i] < vals[j]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nlt[i] = '0;
      nle[i] = '0;
      for (int j = 0; j < 4; j++) begin
        nlt[i] = nlt[i] + 3'(less[i][j]);
        nle[i] = nle[i] + 3'(leq[i][j]);
      end
    end
  end

  // The lower middle of the sorted entries is one with at most rank smaller entries and more than rank not greater.
  assign rank = 2'((cnt - 3'd1) >> 1);

  always_comb begin
    found    = 1'b0;
    pick_val = vals[0];
    for (int i = 0; i < 4; i++) begin
      if (!found && (3'(i) < cnt) && (nlt[i] <= {1'b0, rank}) &&
          (nle[i] > {1'b0, rank})) begin
        pick_val = vals[i];
        found    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res_op)
      m2qs_pkg::RES_ZERO: median_value <= '0;
      m2qs_pkg::RES_AV:   median_value <= av;
      m2qs_pkg::RES_PICK: median_value <= pick_val;
      default: ;
    endcase
  end

  assign st.len_zero  = len_zero;
  assign st.converged = ((ar - al) <= IW'(1)) && ((br - bl) <= IW'(1));
  assign st.pair      = ((cmd.tgt == m2qs_pkg::TGT_A_MID) && a_odd) ||
                        ((cmd.tgt == m2qs_pkg::TGT_B_MID) && b_odd);
  assign st.equal     = (av == bv);
  assign st.a_two     = (ar != al);
  assign st.b_two     = (br != bl);

  a_equal_windows: assert property (@(posedge clk) disable iff (rst)
    (ar - al) == (br - bl))
    else $error("index windows differ in width");

  a_narrow_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.narrow |=> (ar - al) < $past(ar - al))
    else $error("halving round did not shrink the window");

  a_collect_bound: assert property (@(posedge clk) disable iff (rst)
    store_en && collect |-> cnt < 3'd4)
    else $error("more than four entries collected for the sort");

endmodule

@@ hdl/median_of_two_quadratic_sequences.sv @@
// Top level of the median of two quadratic sequences block.
// Depends on m2qs_pkg, the three channel interfaces, m2qs_ctrl and m2qs_dp.
//
//   channel      dir  payload                     transaction when
//   cfg          in   index, data (coefficient)   cfg.valid && cfg.ready
//   seq_in       in   seq_length                  seq_in.valid && seq_in.ready
//   median_out   out  median_value                median_out.valid && median_out.ready
//
// One item is processed at a time on a single shared multiplier. Each quadratic runs square,
// linear, low, high, shift and store steps, plus an averaging step when a midpoint averages two
// entries. About log2(n) halving rounds, ended early when the two midpoint values are equal, are
// followed by two to four evaluations, a compare and a pick; a zero length gives a zero median.
// Reset is synchronous and clears the coefficients to zero. The result waits in its register
// while median_out.ready is low; configuration writes are always accepted.
module median_of_two_quadratic_sequences #(
  parameter int COEF_BITS   = 16,
  parameter int LENGTH_BITS = 20
) (
  input  logic         clk,
  input  logic         rst,
  m2qs_cfg_if.sink     cfg,
  m2qs_len_if.sink     seq_in,
  m2qs_med_if.source   median_out
);

  m2qs_pkg::cmd_t    cmd;
  m2qs_pkg::status_t st;

  assign cfg.ready = 1'b1;

  m2qs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seq_in.valid),
    .in_ready  (seq_in.ready),
    .out_valid (median_out.valid),
    .out_ready (median_out.ready),
    .st        (st),
    .cmd       (cmd)
  );

  m2qs_dp #(
    .COEF_BITS   (COEF_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr       (cfg.valid & cfg.ready),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .seq_length   (seq_in.seq_length),
    .cmd          (cmd),
    .st           (st),
    .median_value (median_out.median_value)
  );

endmodule
